// File: sv/abkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_pkg - shared types, constants and fixed-point helpers
// Fixed-point rounding and saturation for the angle and bias Kalman filter,
// the register map, and the request and response of the divider.
// ----------------------------------------------------------------------------
package abkf_pkg;

  // state banks, one per axis
  localparam int AXES   = 2;
  localparam int BANK_W = (AXES > 1) ? $clog2(AXES) : 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP     = 3'd0,
    CFG_ANGLE_NOISE   = 3'd1,
    CFG_BIAS_NOISE    = 3'd2,
    CFG_MEAS_NOISE    = 3'd3
  } cfg_reg_e;

  localparam logic [23:0] TIME_STEP_RST   = 24'd167772;
  localparam logic [30:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd50332;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd503316;

  // quotient bits produced one per cycle once the overflow check passed
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic               start;
    logic signed [31:0] p;      // numerator, Q8.24
    logic [31:0]        d;      // innovation variance, positive
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;      // gain, Q8.24, saturated
  } div_rsp_t;

  function automatic logic signed [47:0] sx32(input logic signed [31:0] a);
    return {{16{a[31]}}, a};
  endfunction

  function automatic logic signed [47:0] sx41(input logic signed [40:0] a);
    return {{7{a[40]}}, a};
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if ((&v[47:31]) || !(|v[47:31])) begin
      r = v[31:0];
    end else if (v[47]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // v / 2^24, round to nearest, ties away from zero
  function automatic logic signed [40:0] rnd24(input logic signed [63:0] v);
    logic [63:0] m;
    logic [39:0] r;
    logic [40:0] res;
    m   = v[63] ? (~unsigned'(v) + 64'd1) : unsigned'(v);
    r   = 40'((m + 64'd8388608) >> 24);
    res = v[63] ? (~{1'b0, r} + 41'd1) : {1'b0, r};
    return signed'(res);
  endfunction

endpackage

// File: sv/abkf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_div - bit-serial gain divider
// Computes round(p * 2^24 / d), ties away from zero, saturated to 32 bits.
// An overflow check first, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module abkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abkf_pkg::div_req_t req_i,
  output abkf_pkg::div_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    DV_IDLE  = 3'b001,
    DV_CHECK = 3'b010,
    DV_RUN   = 3'b100
  } dv_state_e;

  dv_state_e                      st_q, st_d;
  logic                           done_q, done_d;
  logic [55:0]                    n_q, n_d;
  logic [31:0]                    d_q, d_d;
  logic                           neg_q, neg_d;
  logic                           ovf_q, ovf_d;
  logic [31:0]                    rem_q, rem_d;
  logic [30:0]                    quot_q, quot_d;
  logic [abkf_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic [31:0] mag;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] q_pos;

  always_comb begin
    mag   = req_i.p[31] ? (~unsigned'(req_i.p) + 32'd1) : unsigned'(req_i.p);
    trial = {rem_q, n_q[30]};
    diff  = trial - {1'b0, d_q};
    ge    = (trial >= {1'b0, d_q});
  end

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    n_d    = n_q;
    d_d    = d_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    case (st_q)
      DV_IDLE: begin
        if (req_i.start) begin
          // add half the divisor up front for the rounding
          n_d   = {mag, 24'd0} + {25'd0, req_i.d[31:1]};
          d_d   = req_i.d;
          neg_d = req_i.p[31];
          st_d  = DV_CHECK;
        end
      end
      DV_CHECK: begin
        if ({7'd0, n_q[55:31]} >= d_q) begin
          // quotient reaches 2^31: clamp
          ovf_d  = 1'b1;
          done_d = 1'b1;
          st_d   = DV_IDLE;
        end else begin
          ovf_d  = 1'b0;
          rem_d  = {7'd0, n_q[55:31]};
          quot_d = '0;
          cnt_d  = abkf_pkg::DIV_CNT_W'(abkf_pkg::DIV_STEPS);
          st_d   = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_d  = ge ? diff[31:0] : trial[31:0];
        quot_d = {quot_q[29:0], ge};
        n_d    = {n_q[54:0], 1'b0};
        cnt_d  = cnt_q - abkf_pkg::DIV_CNT_W'(1);
        if (cnt_q == abkf_pkg::DIV_CNT_W'(1)) begin
          done_d = 1'b1;
          st_d   = DV_IDLE;
        end
      end
      default: st_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    q_pos      = {1'b0, quot_q};
    rsp_o.done = done_q;
    if (ovf_q) begin
      rsp_o.q = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rsp_o.q = neg_q ? signed'(~q_pos + 32'd1) : signed'(q_pos);
    end
  end

endmodule

// File: sv/angle_bias_kalman_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_unit - two-state angle and gyro bias filter
// One state bank per axis. Shared 32x32 multiplier and rounding adder under
// a sequencer, plus a bit-serial divider for the two gains.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------
//  in       in         in_valid_i / in_stall_o   axis_i, measured_angle_i,
//                                                gyro_rate_i
//  out      out        out_valid_o / out_stall_i axis_out_o, filtered_angle_o
//  cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  An item is accepted only while the sequencer is idle and no result is
//  waiting for write-back; most of its time goes to the two gain divisions.
//  When the innovation variance is not positive the divisions are skipped,
//  and a saturating gain ends its division at the overflow check.
//  Reset clears the state banks and loads the register defaults; no sweep.
//  A stalled result holds in the output register; the sequencer then waits
//  at write-back until the register frees up.
//
module angle_bias_kalman_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              axis_i,
  input  logic signed [31:0]                measured_angle_i,
  input  logic signed [31:0]                gyro_rate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              axis_out_o,
  output logic signed [31:0]                filtered_angle_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [abkf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [abkf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef enum logic [29:0] {
    ST_IDLE     = 30'd1 << 0,
    ST_LOAD     = 30'd1 << 1,
    ST_RATE     = 30'd1 << 2,
    ST_M_ANG    = 30'd1 << 3,
    ST_A_ANG    = 30'd1 << 4,
    ST_M_T1     = 30'd1 << 5,
    ST_A_T1     = 30'd1 << 6,
    ST_INNER    = 30'd1 << 7,
    ST_CROSS    = 30'd1 << 8,
    ST_M_P00    = 30'd1 << 9,
    ST_A_P00    = 30'd1 << 10,
    ST_M_P11    = 30'd1 << 11,
    ST_A_P11    = 30'd1 << 12,
    ST_GAIN_S   = 30'd1 << 13,
    ST_K0_START = 30'd1 << 14,
    ST_DIV_K0   = 30'd1 << 15,
    ST_DIV_K1   = 30'd1 << 16,
    ST_INNOV    = 30'd1 << 17,
    ST_M_CA     = 30'd1 << 18,
    ST_A_CA     = 30'd1 << 19,
    ST_M_CB     = 30'd1 << 20,
    ST_A_CB     = 30'd1 << 21,
    ST_M_C10    = 30'd1 << 22,
    ST_A_C10    = 30'd1 << 23,
    ST_M_C11    = 30'd1 << 24,
    ST_A_C11    = 30'd1 << 25,
    ST_M_C00    = 30'd1 << 26,
    ST_A_C00    = 30'd1 << 27,
    ST_M_C01    = 30'd1 << 28,
    ST_A_C01    = 30'd1 << 29
  } state_e;

  state_e state_q, state_d;
  logic   wb_q, wb_d;

  // configuration
  logic [23:0] dt_q;
  logic [30:0] qa_q;
  logic [30:0] qb_q;
  logic [30:0] rn_q;

  // state banks
  logic signed [31:0] ang_mem_q [abkf_pkg::AXES];
  logic signed [31:0] bia_mem_q [abkf_pkg::AXES];
  logic signed [31:0] p00_mem_q [abkf_pkg::AXES];
  logic signed [31:0] p01_mem_q [abkf_pkg::AXES];
  logic signed [31:0] p10_mem_q [abkf_pkg::AXES];
  logic signed [31:0] p11_mem_q [abkf_pkg::AXES];

  // working registers
  logic                        axis_q, axis_d;
  logic [abkf_pkg::BANK_W-1:0] bank_q, bank_d;
  logic signed [31:0]          meas_q, meas_d;
  logic signed [31:0]          gyro_q, gyro_d;
  logic signed [31:0]          ang_q, ang_d;
  logic signed [31:0]          bia_q, bia_d;
  logic signed [31:0]          p00_q, p00_d;
  logic signed [31:0]          p01_q, p01_d;
  logic signed [31:0]          p10_q, p10_d;
  logic signed [31:0]          p11_q, p11_d;
  logic signed [31:0]          tmp_q, tmp_d;
  logic signed [31:0]          t1_q, t1_d;
  logic signed [31:0]          k0_q, k0_d;
  logic signed [31:0]          k1_q, k1_d;
  logic [31:0]                 s_q, s_d;
  logic                        pos_q, pos_d;
  logic signed [63:0]          prod_q, prod_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_axis_q, out_axis_d;
  logic signed [31:0] out_angle_q, out_angle_d;

  // shared multiplier and rounding adder
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] acc_x;
  logic               acc_sub;
  logic signed [40:0] rp;
  logic signed [47:0] acc_sum;
  logic signed [31:0] acc_res;
  logic signed [47:0] s_sum;
  logic signed [31:0] dt_s;

  abkf_pkg::div_req_t div_req;
  abkf_pkg::div_rsp_t div_rsp;

  abkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign dt_s = signed'({8'd0, dt_q});

  // multiplier operand select
  always_comb begin
    mul_a = dt_s;
    mul_b = tmp_q;
    case (state_q)
      ST_M_ANG: begin mul_a = dt_s; mul_b = tmp_q; end
      ST_M_T1:  begin mul_a = dt_s; mul_b = p11_q; end
      ST_M_P00: begin mul_a = dt_s; mul_b = tmp_q; end
      ST_M_P11: begin mul_a = signed'({1'b0, qb_q}); mul_b = dt_s; end
      ST_M_CA:  begin mul_a = k0_q; mul_b = tmp_q; end
      ST_M_CB:  begin mul_a = k1_q; mul_b = tmp_q; end
      ST_M_C10: begin mul_a = k1_q; mul_b = p00_q; end
      ST_M_C11: begin mul_a = k1_q; mul_b = p01_q; end
      ST_M_C00: begin mul_a = k0_q; mul_b = p00_q; end
      ST_M_C01: begin mul_a = k0_q; mul_b = p01_q; end
      default:  begin mul_a = dt_s; mul_b = tmp_q; end
    endcase
    prod_d = mul_a * mul_b;
  end

  // add the rounded product to, or subtract it from, the selected state term
  always_comb begin
    acc_x   = '0;
    acc_sub = 1'b0;
    case (state_q)
      ST_A_ANG: acc_x = ang_q;
      ST_A_T1:  acc_x = '0;
      ST_A_P00: acc_x = p00_q;
      ST_A_P11: acc_x = p11_q;
      ST_A_CA:  acc_x = ang_q;
      ST_A_CB:  acc_x = bia_q;
      ST_A_C10: begin acc_x = p10_q; acc_sub = 1'b1; end
      ST_A_C11: begin acc_x = p11_q; acc_sub = 1'b1; end
      ST_A_C00: begin acc_x = p00_q; acc_sub = 1'b1; end
      ST_A_C01: begin acc_x = p01_q; acc_sub = 1'b1; end
      default:  acc_x = '0;
    endcase
    rp      = abkf_pkg::rnd24(prod_q);
    acc_sum = acc_sub ? (abkf_pkg::sx32(acc_x) - abkf_pkg::sx41(rp))
                      : (abkf_pkg::sx32(acc_x) + abkf_pkg::sx41(rp));
    acc_res = abkf_pkg::sat32(acc_sum);
  end

  always_comb begin
    div_req.start = ((state_q == ST_K0_START) && pos_q)
                 || ((state_q == ST_DIV_K0) && div_rsp.done);
    div_req.p     = (state_q == ST_K0_START) ? p00_q : p10_q;
    div_req.d     = s_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    wb_d    = 1'b0;
    axis_d  = axis_q;
    bank_d  = bank_q;
    meas_d  = meas_q;
    gyro_d  = gyro_q;
    ang_d   = ang_q;
    bia_d   = bia_q;
    p00_d   = p00_q;
    p01_d   = p01_q;
    p10_d   = p10_q;
    p11_d   = p11_q;
    tmp_d   = tmp_q;
    t1_d    = t1_q;
    k0_d    = k0_q;
    k1_d    = k1_q;
    s_d     = s_q;
    pos_d   = pos_q;
    s_sum   = abkf_pkg::sx32(p00_q) + signed'({17'd0, rn_q});
    case (state_q)
      ST_IDLE: begin
        if (wb_q && out_valid_q && out_stall_i) begin
          // hold the finished item until the output register frees up
          wb_d = 1'b1;
        end else if (wb_q) begin
          wb_d = 1'b0;
        end else if (in_valid_i) begin
          axis_d  = axis_i;
          bank_d  = (abkf_pkg::AXES > 1) ? abkf_pkg::BANK_W'(axis_i) : '0;
          meas_d  = measured_angle_i;
          gyro_d  = gyro_rate_i;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ang_d   = ang_mem_q[bank_q];
        bia_d   = bia_mem_q[bank_q];
        p00_d   = p00_mem_q[bank_q];
        p01_d   = p01_mem_q[bank_q];
        p10_d   = p10_mem_q[bank_q];
        p11_d   = p11_mem_q[bank_q];
        state_d = ST_RATE;
      end
      ST_RATE: begin
        tmp_d   = abkf_pkg::sat32(abkf_pkg::sx32(gyro_q) - abkf_pkg::sx32(bia_q));
        state_d = ST_M_ANG;
      end
      ST_M_ANG: state_d = ST_A_ANG;
      ST_A_ANG: begin
        ang_d   = acc_res;
        state_d = ST_M_T1;
      end
      ST_M_T1: state_d = ST_A_T1;
      ST_A_T1: begin
        t1_d    = acc_res;
        state_d = ST_INNER;
      end
      ST_INNER: begin
        tmp_d   = abkf_pkg::sat32(abkf_pkg::sx32(t1_q) - abkf_pkg::sx32(p01_q)
                                  - abkf_pkg::sx32(p10_q) + signed'({17'd0, qa_q}));
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        p01_d   = abkf_pkg::sat32(abkf_pkg::sx32(p01_q) - abkf_pkg::sx32(t1_q));
        p10_d   = abkf_pkg::sat32(abkf_pkg::sx32(p10_q) - abkf_pkg::sx32(t1_q));
        state_d = ST_M_P00;
      end
      ST_M_P00: state_d = ST_A_P00;
      ST_A_P00: begin
        p00_d   = acc_res;
        state_d = ST_M_P11;
      end
      ST_M_P11: state_d = ST_A_P11;
      ST_A_P11: begin
        p11_d   = acc_res;
        state_d = ST_GAIN_S;
      end
      ST_GAIN_S: begin
        s_d     = s_sum[31:0];
        pos_d   = !s_sum[47] && (s_sum != '0);
        state_d = ST_K0_START;
      end
      ST_K0_START: begin
        if (pos_q) begin
          state_d = ST_DIV_K0;
        end else begin
          k0_d    = '0;
          k1_d    = '0;
          state_d = ST_INNOV;
        end
      end
      ST_DIV_K0: begin
        if (div_rsp.done) begin
          k0_d    = div_rsp.q;
          state_d = ST_DIV_K1;
        end
      end
      ST_DIV_K1: begin
        if (div_rsp.done) begin
          k1_d    = div_rsp.q;
          state_d = ST_INNOV;
        end
      end
      ST_INNOV: begin
        tmp_d   = abkf_pkg::sat32(abkf_pkg::sx32(meas_q) - abkf_pkg::sx32(ang_q));
        state_d = ST_M_CA;
      end
      ST_M_CA: state_d = ST_A_CA;
      ST_A_CA: begin
        ang_d   = acc_res;
        state_d = ST_M_CB;
      end
      ST_M_CB: state_d = ST_A_CB;
      ST_A_CB: begin
        bia_d   = acc_res;
        state_d = ST_M_C10;
      end
      ST_M_C10: state_d = ST_A_C10;
      ST_A_C10: begin
        p10_d   = acc_res;
        state_d = ST_M_C11;
      end
      ST_M_C11: state_d = ST_A_C11;
      ST_A_C11: begin
        p11_d   = acc_res;
        state_d = ST_M_C00;
      end
      ST_M_C00: state_d = ST_A_C00;
      ST_A_C00: begin
        p00_d   = acc_res;
        state_d = ST_M_C01;
      end
      ST_M_C01: state_d = ST_A_C01;
      ST_A_C01: begin
        p01_d   = acc_res;
        wb_d    = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result post: the item sits in the working registers while wb_q is set
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_axis_d  = out_axis_q;
    out_angle_d = out_angle_q;
    if (wb_q && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_axis_d  = axis_q;
      out_angle_d = ang_q;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE) || wb_q;
  assign out_valid_o      = out_valid_q;
  assign axis_out_o       = out_axis_q;
  assign filtered_angle_o = out_angle_q;
  assign cfg_ready_o      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wb_q        <= 1'b0;
      out_valid_q <= 1'b0;
      dt_q        <= abkf_pkg::TIME_STEP_RST;
      qa_q        <= abkf_pkg::ANGLE_NOISE_RST;
      qb_q        <= abkf_pkg::BIAS_NOISE_RST;
      rn_q        <= abkf_pkg::MEAS_NOISE_RST;
    end else begin
      state_q     <= state_d;
      wb_q        <= wb_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          abkf_pkg::CFG_TIME_STEP:   dt_q <= cfg_data_i[23:0];
          abkf_pkg::CFG_ANGLE_NOISE: qa_q <= cfg_data_i[30:0];
          abkf_pkg::CFG_BIAS_NOISE:  qb_q <= cfg_data_i[30:0];
          abkf_pkg::CFG_MEAS_NOISE:  rn_q <= cfg_data_i[30:0];
          default: ;  // drop writes past the register map
        endcase
      end
    end
  end

  // state banks, written back once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < abkf_pkg::AXES; i++) begin
        ang_mem_q[i] <= '0;
        bia_mem_q[i] <= '0;
        p00_mem_q[i] <= '0;
        p01_mem_q[i] <= '0;
        p10_mem_q[i] <= '0;
        p11_mem_q[i] <= '0;
      end
    end else if (state_q == ST_A_C01) begin
      ang_mem_q[bank_q] <= ang_q;
      bia_mem_q[bank_q] <= bia_q;
      p00_mem_q[bank_q] <= p00_q;
      p01_mem_q[bank_q] <= acc_res;
      p10_mem_q[bank_q] <= p10_q;
      p11_mem_q[bank_q] <= p11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q      <= axis_d;
    bank_q      <= bank_d;
    meas_q      <= meas_d;
    gyro_q      <= gyro_d;
    ang_q       <= ang_d;
    bia_q       <= bia_d;
    p00_q       <= p00_d;
    p01_q       <= p01_d;
    p10_q       <= p10_d;
    p11_q       <= p11_d;
    tmp_q       <= tmp_d;
    t1_q        <= t1_d;
    k0_q        <= k0_d;
    k1_q        <= k1_d;
    s_q         <= s_d;
    pos_q       <= pos_d;
    prod_q      <= prod_d;
    out_axis_q  <= out_axis_d;
    out_angle_q <= out_angle_d;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_LOAD))
    else $error("accepted request did not start a bank load");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_K0 || state_q == ST_DIV_K1))
    else $error("divider finished while the sequencer was not waiting");

  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INNOV && !pos_q) |-> (k0_q == '0 && k1_q == '0))
    else $error("nonzero gain with a non-positive innovation variance");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_q && (!out_valid_q || !out_stall_i))
      |=> (out_valid_q && out_angle_q == $past(ang_q) && !wb_q))
    else $error("finished item not moved into the output register");

endmodule
